// ----- sv/pul_pkg.sv -----
// ----------------------------------------------------------------------------
// pul_pkg
// Shared types and constants for the permutation unrank unit: field widths,
// the sequencer state type and the factorial table.
// ----------------------------------------------------------------------------
package pul_pkg;

   localparam int RANK_W  = 62;
   localparam int FIELD_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_EMIT
   } state_type;

   // j! for j = 0..19; unused codes give 1
   function automatic logic [RANK_W-1:0] fact_f(input logic [FIELD_W-1:0] j);
      logic [RANK_W-1:0] f;
      case (j)
         5'd0:    f = 62'd1;
         5'd1:    f = 62'd1;
         5'd2:    f = 62'd2;
         5'd3:    f = 62'd6;
         5'd4:    f = 62'd24;
         5'd5:    f = 62'd120;
         5'd6:    f = 62'd720;
         5'd7:    f = 62'd5040;
         5'd8:    f = 62'd40320;
         5'd9:    f = 62'd362880;
         5'd10:   f = 62'd3628800;
         5'd11:   f = 62'd39916800;
         5'd12:   f = 62'd479001600;
         5'd13:   f = 62'd6227020800;
         5'd14:   f = 62'd87178291200;
         5'd15:   f = 62'd1307674368000;
         5'd16:   f = 62'd20922789888000;
         5'd17:   f = 62'd355687428096000;
         5'd18:   f = 62'd6402373705728000;
         5'd19:   f = 62'd121645100408832000;
         default: f = 62'd1;
      endcase
      return f;
   endfunction

endpackage

// ----- sv/pul_free_pick.sv -----
// ----------------------------------------------------------------------------
// pul_free_pick
// Finds the lowest unused value index at or above a start index, among the
// first len values.
// ----------------------------------------------------------------------------
module pul_free_pick
   import pul_pkg::*;
#(
   parameter int MAX_LEN = 20,
   parameter int IDX_W   = 5
) (
   input  logic [MAX_LEN-1:0] used_mask,
   input  logic [FIELD_W-1:0] len,
   input  logic [IDX_W:0]     from_idx,
   output logic [IDX_W-1:0]   pick_idx
);

   logic [MAX_LEN-1:0] free_mask;

   always_comb begin
      for (int j = 0; j < MAX_LEN; j++) begin
         free_mask[j] = !used_mask[j] && (FIELD_W'(j) < len) && ((IDX_W+1)'(j) >= from_idx);
      end
   end

   // lowest set bit wins: scan downwards so the last hit is the lowest
   always_comb begin
      pick_idx = '0;
      for (int j = MAX_LEN - 1; j >= 0; j--) begin
         if (free_mask[j]) begin
            pick_idx = IDX_W'(j);
         end
      end
   end

endmodule

// ----- sv/permutation_unrank_lexicographic_unit.sv -----
// ----------------------------------------------------------------------------
// permutation_unrank_lexicographic_unit
// Decodes a lexicographic rank into the elements of a permutation of 1..n.
// ----------------------------------------------------------------------------
// One item carries a zero-based rank and a length n; the unit returns n items,
// element values in position order, with is_last set on the final one. A
// length of zero gives no results and a length above MAX_LEN is taken as
// MAX_LEN. Each digit (rank divided by the remaining factorial, clamped to the
// number of remaining positions, so a too-large rank saturates toward the
// last permutation) is found by repeated subtraction of the factorial in one
// shared 62-bit compare/subtract unit, one step a cycle; each step also walks
// a pointer to the next unused value, so the chosen element is ready when the
// digit is. Each position seeds its candidate in ST_START, counts its digit
// d_i in ST_DIV by d_i subtractions and a last compare that stops, and is
// held in ST_EMIT until rsp_ready takes the result.
// The unit takes a new item only when the previous one has been fully
// delivered.
// ----------------------------------------------------------------------------
module permutation_unrank_lexicographic_unit
   import pul_pkg::*;
#(
   parameter int MAX_LEN = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [RANK_W-1:0]   req_rank_index,
   input  logic [FIELD_W-1:0]  req_perm_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [FIELD_W-1:0]  rsp_element_value,
   output logic [FIELD_W-1:0]  rsp_position,
   output logic                rsp_is_last
);

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [FIELD_W-1:0] LEN_MAX = FIELD_W'(MAX_LEN);

   state_type          state_ff, state_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;      // remaining rank
   logic [FIELD_W-1:0] len_ff, len_in;        // saturated length
   logic [FIELD_W-1:0] rem_ff, rem_in;        // positions left after this one
   logic [FIELD_W-1:0] pos_ff, pos_in;        // current position
   logic [FIELD_W-1:0] digit_ff, digit_in;    // digit counted so far
   logic [IDX_W-1:0]   val_ff, val_in;        // candidate element, zero based
   logic [MAX_LEN-1:0] used_ff, used_in;

   logic [RANK_W-1:0]  fact;
   logic               rank_ge;
   logic [IDX_W:0]     from_idx;
   logic [IDX_W-1:0]   pick_idx;

   // shared compare/subtract operand
   assign fact    = fact_f(rem_ff);
   assign rank_ge = rank_ff >= fact;

   // the start of a digit looks from the bottom, each step looks above the candidate
   assign from_idx = (state_ff == ST_START) ? '0 : ({1'b0, val_ff} + (IDX_W+1)'(1));

   pul_free_pick #(
      .MAX_LEN (MAX_LEN),
      .IDX_W   (IDX_W)
   ) u_pick (
      .used_mask (used_ff),
      .len       (len_ff),
      .from_idx  (from_idx),
      .pick_idx  (pick_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff  <= rank_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      digit_ff <= digit_in;
      val_ff   <= val_in;
      used_ff  <= used_in;
   end

   always_comb begin
      state_in = state_ff;
      rank_in  = rank_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      digit_in = digit_ff;
      val_in   = val_ff;
      used_in  = used_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rank_in  = req_rank_index;
               len_in   = (req_perm_length > LEN_MAX) ? LEN_MAX : req_perm_length;
               rem_in   = len_in - FIELD_W'(1);
               pos_in   = '0;
               digit_in = '0;
               used_in  = '0;
               // drop zero-length items
               if (req_perm_length != '0) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            // seed the candidate with the smallest unused value
            val_in   = pick_idx;
            digit_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one subtraction per cycle, advance the candidate alongside
            if (digit_ff != rem_ff && rank_ge) begin
               rank_in  = rank_ff - fact;
               digit_in = digit_ff + FIELD_W'(1);
               val_in   = pick_idx;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               used_in[val_ff] = 1'b1;
               if (rem_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rem_in   = rem_ff - FIELD_W'(1);
                  pos_in   = pos_ff + FIELD_W'(1);
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_element_value = FIELD_W'(val_ff) + FIELD_W'(1);
   assign rsp_position      = pos_ff;
   assign rsp_is_last       = (rem_ff == '0);

   // a result never shares a cycle with input acceptance
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result valid while taking input");

   // the digit never passes the clamp
   a_digit_clamp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (digit_ff <= rem_ff))
      else $error("digit above remaining positions");

   // an emitted element must not have been used before
   a_fresh_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |-> !used_ff[val_ff])
      else $error("element value repeated");

   // delivering the last element frees the input side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_is_last) |=> req_ready)
      else $error("not ready after last element");

endmodule

// ----- tb/sv/permutation_unrank_checker.sv -----
// ----------------------------------------------------------------------------
// permutation_unrank_checker
// Watches both channels of the unrank unit, works out the permutation for each
// accepted request and compares every delivered element against it in order.
// ----------------------------------------------------------------------------
module permutation_unrank_checker
   import pul_pkg::*;
#(
   parameter int MAX_LEN = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [RANK_W-1:0]   req_rank_index,
   input  logic [FIELD_W-1:0]  req_perm_length,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [FIELD_W-1:0]  rsp_element_value,
   input  logic [FIELD_W-1:0]  rsp_position,
   input  logic                rsp_is_last,
   output int                  failures,
   output int                  pending,
   output int                  requests_seen,
   output int                  elements_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] pos;
      logic               last;
   } element_type;

   element_type expected_elements[$];
   int          fail_total = 0;
   int          req_total  = 0;
   int          elem_total = 0;

   function automatic logic [63:0] factorial(input int j);
      logic [63:0] f;
      f = 64'd1;
      for (int m = 2; m <= j; m++) f = f * 64'(m);
      return f;
   endfunction

   // Decode the Lehmer digits of the rank and queue the resulting elements
   function automatic void queue_permutation(input logic [RANK_W-1:0] rank,
                                             input logic [FIELD_W-1:0] len);
      logic [63:0] k;
      logic [63:0] f;
      logic [63:0] digit;
      logic [31:0] taken;
      int          n;
      int          rem;
      int          seen;
      int          pick;
      element_type e;
      k     = 64'(rank);
      n     = int'(len);
      taken = '0;
      if (n > MAX_LEN) n = MAX_LEN;
      for (int i = 0; i < n; i++) begin
         rem   = n - 1 - i;
         f     = factorial(rem);
         digit = k / f;
         if (digit > 64'(rem)) digit = 64'(rem);
         k     = k - digit * f;
         seen  = 0;
         pick  = 0;
         for (int v = 0; v < n; v++) begin
            if (!taken[v] && pick == 0) begin
               if (64'(seen) == digit) pick = v + 1;
               seen++;
            end
         end
         taken[pick-1] = 1'b1;
         e.value = FIELD_W'(pick);
         e.pos   = FIELD_W'(i);
         e.last  = (i == n - 1);
         expected_elements.push_back(e);
      end
   endfunction

   always @(posedge clock) begin
      element_type got;
      element_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_permutation(req_rank_index, req_perm_length);
            req_total++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_element_value, rsp_position, rsp_is_last};
            elem_total++;
            if (expected_elements.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("[%0t] unexpected element: value %0d position %0d last %0b",
                           $realtime, got.value, got.pos, got.last);
            end else begin
               want = expected_elements.pop_front();
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $write("[%0t] element %0d mismatch: expected value %0d pos %0d last %0b,",
                            $realtime, elem_total, want.value, want.pos, want.last);
                     $display(" got value %0d pos %0d last %0b",
                              got.value, got.pos, got.last);
                  end
               end
            end
         end
      end
      failures      <= fail_total;
      pending       <= expected_elements.size();
      requests_seen <= req_total;
      elements_seen <= elem_total;
   end

endmodule

// ----- tb/sv/tb_permutation_unrank_lexicographic_unit.sv -----
// ----------------------------------------------------------------------------
// tb_permutation_unrank_lexicographic_unit
// Drives ranks and lengths into the unrank unit with random gaps and stalls.
// ----------------------------------------------------------------------------
// A short directed burst hits the corner cases (shortest and longest lengths,
// first and last ranks, ranks past n! that saturate, zero and over-long
// lengths), then several hundred random requests follow, most of them with a
// rank below n! so that every digit value turns up. The checker beside the
// unit predicts and compares each element; this module only makes stimulus,
// keeps a watchdog running and gives the verdict.
// ----------------------------------------------------------------------------
module tb_permutation_unrank_lexicographic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import pul_pkg::*;

   localparam int MAX_LEN         = 20;
   localparam int RANDOM_ITEMS    = 425;
   localparam int IDLE_PERCENT    = 28;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 5000;  // watchdog limit on cycles without a handshake
   localparam int DRAIN_CYCLES    = 250;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [RANK_W-1:0]   req_rank_index  = '0;
   logic [FIELD_W-1:0]  req_perm_length = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [FIELD_W-1:0]  rsp_element_value;
   logic [FIELD_W-1:0]  rsp_position;
   logic                rsp_is_last;

   int failures;
   int pending;
   int requests_seen;
   int elements_seen;

   int accepted_reqs = 0;
   int idle_cycles   = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   bit gaps_on       = 1'b1;
   int zero_len      = 0;
   int over_len      = 0;
   int saturating    = 0;

   always #5 clock = ~clock;

   permutation_unrank_lexicographic_unit #(
      .MAX_LEN (MAX_LEN)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rank_index    (req_rank_index),
      .req_perm_length   (req_perm_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_element_value (rsp_element_value),
      .rsp_position      (rsp_position),
      .rsp_is_last       (rsp_is_last)
   );

   permutation_unrank_checker #(
      .MAX_LEN (MAX_LEN)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rank_index    (req_rank_index),
      .req_perm_length   (req_perm_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_element_value (rsp_element_value),
      .rsp_position      (rsp_position),
      .rsp_is_last       (rsp_is_last),
      .failures          (failures),
      .pending           (pending),
      .requests_seen     (requests_seen),
      .elements_seen     (elements_seen)
   );

   function automatic logic [63:0] fact_of(input int j);
      logic [63:0] f;
      f = 64'd1;
      for (int m = 2; m <= j; m++) f = f * 64'(m);
      return f;
   endfunction

   // Count accepted requests and watch for a stuck handshake
   always @(posedge clock) begin
      if (req_valid && req_ready) accepted_reqs <= accepted_reqs + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles, %0d elements outstanding",
                  $realtime, idle_cycles, pending);
         $display("** permutation_unrank_lexicographic_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random back-pressure, one long hold-off so the unit fills up
   // and stalls its input, and a calm stretch with ready held high
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= 100) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (accepted_reqs >= 250 && accepted_reqs < 330) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Offer one request and hold it until the unit takes it; call at a rising edge
   task automatic offer(input logic [RANK_W-1:0] rank, input logic [FIELD_W-1:0] len);
      int n;
      n = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
      if (len == 0) zero_len++;
      if (int'(len) > MAX_LEN) over_len++;
      if (len != 0 && 64'(rank) >= fact_of(n)) saturating++;
      if (gaps_on) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_rank_index  <= rank;
      req_perm_length <= len;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      logic [63:0] r64;
      int          n;
      int          kind;
      int          counted;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: first and last ranks, saturation, odd lengths
      offer(62'd0, 5'd1);
      offer({RANK_W{1'b1}}, 5'd1);
      offer(62'd0, 5'd20);
      offer(62'd1, 5'd20);
      offer(62'(fact_of(19)), 5'd20);
      offer(62'(fact_of(20) - 64'd1), 5'd20);
      offer(62'(fact_of(20)), 5'd20);
      offer({RANK_W{1'b1}}, 5'd20);
      offer(62'd5, 5'd3);
      offer(62'd6, 5'd3);
      offer(62'd1, 5'd2);
      offer(62'd3, 5'd4);
      offer(62'(fact_of(10) - 64'd1), 5'd10);
      offer(62'(fact_of(13) / 64'd2), 5'd13);
      offer({31{2'b01}}, 5'd20);
      offer({31{2'b10}}, 5'd20);
      offer(62'd0, 5'd0);
      offer(62'd123, 5'd0);
      offer(62'd0, 5'd21);
      offer({31{2'b10}}, 5'd31);
      offer({RANK_W{1'b1}}, 5'd31);
      offer(62'(fact_of(19) * 64'd7 + 64'd12345), 5'd20);

      // Random part: mostly in-range ranks, some saturating and odd lengths
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         gaps_on = !(counted >= 200 && counted < 300);
         kind    = $urandom_range(99);
         r64     = {$urandom, $urandom};
         if (kind < 70) begin
            n = $urandom_range(20, 1);
            offer(62'(r64 % fact_of(n)), 5'(n));
         end else if (kind < 80) begin
            n = $urandom_range(8, 1);
            offer(r64[0] ? 62'(fact_of(n) - 64'd1) : 62'd0, 5'(n));
         end else if (kind < 90) begin
            n = $urandom_range(20, 1);
            offer(r64[RANK_W-1:0], 5'(n));
         end else if (kind < 95) begin
            n = $urandom_range(31, 21);
            offer(r64[RANK_W-1:0], 5'(n));
         end else begin
            n = 0;
            offer(r64[RANK_W-1:0], 5'd0);
         end
         if (n != 0) counted++;
      end
      req_valid <= 1'b0;

      // Let the checker see the last request, then drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d zero length, %0d over-long, %0d saturating ranks)",
               requests_seen, zero_len, over_len, saturating);
      $display("and checked %0d permutation elements with %0d mismatches.",
               elements_seen, failures);
      if (failures == 0) begin
         $display("** permutation_unrank_lexicographic_unit: PASSED **");
      end else begin
         $display("** permutation_unrank_lexicographic_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/pul_pkg.sv
sv/pul_free_pick.sv
sv/permutation_unrank_lexicographic_unit.sv
tb/sv/permutation_unrank_checker.sv
tb/sv/tb_permutation_unrank_lexicographic_unit.sv
